// ===== rtl/core/mfm_flux_interval_classifier_macros.svh =====
// assertion macros for the mfm flux interval classifier
// expects clk in the scope of each use, and rst too for MFMFIC_ASSERT
`ifndef MFM_FLUX_INTERVAL_CLASSIFIER_MACROS_SVH
`define MFM_FLUX_INTERVAL_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define MFMFIC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mfmfic assertion failed");
`define MFMFIC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mfmfic assertion failed");
`else
`define MFMFIC_ASSERT(lbl, prop)
`define MFMFIC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/core/mfmfic_pkg.sv =====
// shared types and constants for the mfm flux interval classifier
// no dependencies
`default_nettype none
package mfmfic_pkg;

  localparam int IntervalW = 8;
  localparam int TargetW   = 20;
  localparam int TotalW    = 21;
  localparam int CellsW    = 3;
  localparam int CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] REG_SHORT_LIMIT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_LIMIT   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TARGET_CELLS = 2'd2;

  localparam logic [IntervalW-1:0] SHORT_LIMIT_RST  = 8'd80;
  localparam logic [IntervalW-1:0] LONG_LIMIT_RST   = 8'd111;
  localparam logic [TargetW-1:0]   TARGET_CELLS_RST = 20'd111104;

  localparam logic [1:0] CODE_SHORT = 2'b01;
  localparam logic [1:0] CODE_MID   = 2'b10;
  localparam logic [1:0] CODE_LONG  = 2'b11;

  localparam logic [CellsW-1:0] CELLS_SHORT = 3'd2;
  localparam logic [CellsW-1:0] CELLS_MID   = 3'd3;
  localparam logic [CellsW-1:0] CELLS_LONG  = 3'd4;

  localparam logic [1:0] LAST_CODE_SLOT = 2'd3;

  localparam logic [7:0] END_MARKER = 8'h00;

  typedef struct packed {
    logic       data_en;
    logic       mark_en;
    logic [7:0] data_byte;
  } push_t;

endpackage
`default_nettype wire

// ===== rtl/core/mfm_flux_interval_classifier.sv =====
// top level of the mfm flux interval classifier: config registers and output stage
// depends on mfmfic_pkg, mfmfic_classify and the assertion macro header
//
// channel   dir  fields (low bit up)
// s_axis    in   tuser: req_type   tdata: interval[7:0]
// m_axis    out  tdata: out_byte[7:0]   tlast: last
// cfg       in   cfg_index selects short_limit, long_limit, target_cells
//
// one item per cycle in; a completed byte sits in the output register the cycle after its item
// input waits while the output register is full and not being taken
// a byte that ends the track is followed by its end marker from a second slot;
// input waits until that byte leaves the output register
// rst is synchronous: idle, limits and target back to their defaults
`default_nettype none
`include "mfm_flux_interval_classifier_macros.svh"
module mfm_flux_interval_classifier (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [mfmfic_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [mfmfic_pkg::TargetW-1:0]     cfg_data,
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  input  wire logic [mfmfic_pkg::IntervalW-1:0]   s_axis_tdata,   // interval
  input  wire logic                               s_axis_tuser,   // req_type
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output      logic [7:0]                         m_axis_tdata,   // out_byte
  output      logic                               m_axis_tlast
);
  import mfmfic_pkg::*;

  logic [IntervalW-1:0] short_limit;
  logic [IntervalW-1:0] long_limit;
  logic [TargetW-1:0]   target_cells;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       pend;
  logic       pop;
  logic       accept;
  push_t      push;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_limit  <= SHORT_LIMIT_RST;
      long_limit   <= LONG_LIMIT_RST;
      target_cells <= TARGET_CELLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_LIMIT:  short_limit  <= cfg_data[IntervalW-1:0];
        REG_LONG_LIMIT:   long_limit   <= cfg_data[IntervalW-1:0];
        REG_TARGET_CELLS: target_cells <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pop           = out_valid && m_axis_tready;
  assign s_axis_tready = !pend && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  mfmfic_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .req_type     (s_axis_tuser),
    .interval     (s_axis_tdata),
    .short_limit  (short_limit),
    .long_limit   (long_limit),
    .target_cells (target_cells),
    .push         (push)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (push.data_en) begin
      out_valid <= 1'b1;
      pend      <= push.mark_en;
    end else if (pop) begin
      out_valid <= pend;
      pend      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.data_en) begin
      out_byte <= push.data_byte;
      out_last <= 1'b0;
    end else if (pop && pend) begin
      out_byte <= END_MARKER;
      out_last <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tlast  = out_last;

  `MFMFIC_ASSERT(a_pend_behind_data, pend |-> out_valid && !out_last)
  `MFMFIC_ASSERT(a_push_has_room, push.data_en |-> !pend && (!out_valid || m_axis_tready))
  `MFMFIC_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid && !pend)

endmodule
`default_nettype wire

// ===== rtl/core/mfmfic_classify.sv =====
// interval classification, code packing and cell counting
// depends on mfmfic_pkg and the assertion macro header
`default_nettype none
`include "mfm_flux_interval_classifier_macros.svh"
module mfmfic_classify (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 accept,
  input  wire logic                                 req_type,
  input  wire logic [mfmfic_pkg::IntervalW-1:0]     interval,
  input  wire logic [mfmfic_pkg::IntervalW-1:0]     short_limit,
  input  wire logic [mfmfic_pkg::IntervalW-1:0]     long_limit,
  input  wire logic [mfmfic_pkg::TargetW-1:0]       target_cells,
  output mfmfic_pkg::push_t                         push
);
  import mfmfic_pkg::*;

  logic              active;
  logic [1:0]        code_count;
  logic [TotalW-1:0] cell_total;
  logic [7:0]        packed_codes;

  logic              start;
  logic              step;
  logic [1:0]        code;
  logic [CellsW-1:0] cells;
  logic [TotalW:0]   sum;
  logic [TotalW-1:0] cell_total_next;
  logic [7:0]        packed_codes_next;
  logic [TargetW-1:0] goal;
  logic              byte_done;
  logic              done;

  always_comb begin
    start = accept && !req_type;
    step  = accept && req_type && active;
    if (interval < short_limit) begin
      code  = CODE_SHORT;
      cells = CELLS_SHORT;
    end else if (interval > long_limit) begin
      code  = CODE_LONG;
      cells = CELLS_LONG;
    end else begin
      code  = CODE_MID;
      cells = CELLS_MID;
    end
    sum = {1'b0, cell_total} + (TotalW + 1)'(cells);
    cell_total_next = sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];
    packed_codes_next = {packed_codes[5:0], code};
    goal = (target_cells == '0) ? TargetW'(1) : target_cells;
    byte_done = (code_count == LAST_CODE_SLOT);
    done = byte_done && (cell_total_next >= {1'b0, goal});
    push.data_en   = step && byte_done;
    push.mark_en   = step && done;
    push.data_byte = packed_codes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      code_count <= '0;
      cell_total <= '0;
    end else if (start) begin
      active     <= 1'b1;
      code_count <= '0;
      cell_total <= '0;
    end else if (step) begin
      code_count <= code_count + 2'd1;
      cell_total <= cell_total_next;
      if (done) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      packed_codes <= '0;
    end else if (step) begin
      packed_codes <= packed_codes_next;
    end
  end

  `MFMFIC_ASSERT(a_mark_with_data, push.mark_en |-> push.data_en)
  `MFMFIC_ASSERT(a_idle_after_mark, push.mark_en |=> !active)
  `MFMFIC_ASSERT(a_byte_on_fourth, push.data_en |-> code_count == LAST_CODE_SLOT && active)

endmodule
`default_nettype wire
